### rtl/core/lmg_pkg.sv
// shared types and constants for the letter bigram generator
package lmg_pkg;

    localparam int MODE_W   = 2;
    localparam int LETTER_W = 5;
    localparam int RAND_W   = 32;
    localparam int SYMBOL_W = 5;
    localparam int LEN_W    = 6;
    localparam int STEP_W   = $clog2(RAND_W);

    localparam logic [MODE_W-1:0] MODE_TRAIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_END     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

    localparam logic [LEN_W-1:0] CAP_RESET = 6'd63;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic train_write;
        logic sweep_start;
        logic sweep_run;
        logic scan;
        logic div_start;
        logic finish;
    } lmg_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              letter_ok;
        logic              train_open;
        logic              sweep_done;
        logic              div_done;
        logic              clear_done;
        logic              total_zero;
        logic              out_free;
    } lmg_stat_t;

endpackage

### rtl/core/lmg_div.sv
// iterative restoring divider, one quotient bit per cycle, remainder only
module lmg_div #(
    parameter int DIV_W = 37
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lmg_pkg::RAND_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          rem
);

    logic [lmg_pkg::RAND_W-1:0] quo_reg;
    logic [DIV_W-1:0]           dvs_reg;
    logic [DIV_W-1:0]           rem_reg;
    logic [DIV_W-1:0]           rem_next;
    logic [lmg_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [DIV_W:0]             trial;
    logic                       ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[lmg_pkg::RAND_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == lmg_pkg::STEP_W'(lmg_pkg::RAND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[lmg_pkg::RAND_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### rtl/core/lmg_dp.sv
// datapath: count memory, sweep accumulator, divider, generator state, output register
module lmg_dp #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_BITS    = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [39:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              cfg_valid,
    input  logic [5:0]        cfg_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser,
    input  lmg_pkg::lmg_cmd_t cmd,
    output lmg_pkg::lmg_stat_t stat
);

    localparam int ROW_LEN = ALPHABET_SIZE + 1;
    localparam int SYM_W   = $clog2(ROW_LEN);
    localparam int DEPTH   = ROW_LEN * ROW_LEN;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int TOT_W   = COUNT_BITS + SYM_W;
    localparam logic [SYM_W-1:0] END_SYM = SYM_W'(ALPHABET_SIZE);

    // row ALPHABET_SIZE holds the start counts, other rows the successor counts
    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic [lmg_pkg::MODE_W-1:0] mode_reg;
    logic [SYM_W-1:0]           letter_reg;
    logic                       letter_ok_reg;
    logic [lmg_pkg::RAND_W-1:0] rnd_reg;
    logic [SYM_W-1:0]           train_prev_reg;
    logic [SYM_W-1:0]           gen_prev_reg;
    logic [SYM_W-1:0]           gen_prev_next;
    logic [lmg_pkg::LEN_W-1:0]  gen_len_reg;
    logic [lmg_pkg::LEN_W-1:0]  gen_len_next;
    logic [lmg_pkg::LEN_W-1:0]  cap_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic [SYM_W-1:0]           iss_col_reg;
    logic                       iss_done_reg;
    logic [SYM_W-1:0]           rd_col_reg;
    logic                       rd_vld_reg;
    logic [TOT_W-1:0]           acc_reg;
    logic [SYM_W-1:0]           pick_reg;
    logic [COUNT_BITS-1:0]      rd_data_reg;
    logic                       m_tvalid_reg;
    logic [lmg_pkg::SYMBOL_W-1:0] sym_out_reg;
    logic                       wend_reg;
    logic                       stat_reg;

    logic [SYM_W+lmg_pkg::LETTER_W-1:0] letter_ext;
    logic [SYM_W+lmg_pkg::SYMBOL_W-1:0] sym_ext;
    logic                  draw;
    logic [SYM_W-1:0]      row;
    logic [SYM_W-1:0]      col;
    logic [SYM_W-1:0]      last_col;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [TOT_W-1:0]      acc_sum;
    logic [TOT_W-1:0]      div_rem;
    logic [TOT_W-1:0]      target;
    logic                  div_done;
    logic                  hit;
    logic                  empty;
    logic [lmg_pkg::LEN_W-1:0] cap;
    logic [lmg_pkg::LEN_W-1:0] len_inc;
    logic [SYM_W-1:0]      res_sym;
    logic                  res_end;
    logic                  res_stat;
    logic                  out_free;

    lmg_div #(
        .DIV_W (TOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rnd_reg),
        .divisor  (acc_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign letter_ext = {{SYM_W{1'b0}}, s_tdata[lmg_pkg::LETTER_W-1:0]};

    always_comb
    begin
        draw     = mode_reg == lmg_pkg::MODE_DRAW;
        row      = draw ? gen_prev_reg : train_prev_reg;
        col      = draw ? iss_col_reg
                 : ((mode_reg == lmg_pkg::MODE_END) ? END_SYM : letter_reg);
        rd_addr  = ADDR_W'(ADDR_W'(row) * ADDR_W'(ROW_LEN)) + ADDR_W'(col);
        last_col = (gen_prev_reg == END_SYM) ? END_SYM - 1'b1 : END_SYM;
        acc_sum  = acc_reg + TOT_W'(rd_data_reg);
        target   = div_rem + 1'b1;
        hit      = rd_vld_reg && ((acc_sum >= target) || (rd_col_reg == last_col));
        we       = cmd.clear_step || cmd.train_write;
        wr_addr  = cmd.clear_step ? clr_addr_reg : rd_addr;
        // zero on clear, otherwise a saturating bump
        if (cmd.clear_step)
            wr_data = '0;
        else if (rd_data_reg == {COUNT_BITS{1'b1}})
            wr_data = rd_data_reg;
        else
            wr_data = rd_data_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // result of a finished item
    always_comb
    begin
        empty         = acc_reg == '0;
        cap           = (cap_reg == '0) ? lmg_pkg::LEN_W'(1) : cap_reg;
        len_inc       = gen_len_reg + 1'b1;
        res_sym       = '0;
        res_end       = 1'b0;
        res_stat      = 1'b0;
        gen_prev_next = gen_prev_reg;
        gen_len_next  = gen_len_reg;
        unique case (mode_reg)
            lmg_pkg::MODE_DRAW:
            begin
                if (gen_prev_reg == END_SYM)
                begin
                    if (empty)
                    begin
                        res_sym  = END_SYM;
                        res_end  = 1'b1;
                        res_stat = 1'b1;
                    end
                    else
                    begin
                        res_sym = pick_reg;
                        if (cap <= lmg_pkg::LEN_W'(1))
                        begin
                            res_end       = 1'b1;
                            gen_prev_next = END_SYM;
                            gen_len_next  = '0;
                        end
                        else
                        begin
                            gen_prev_next = pick_reg;
                            gen_len_next  = lmg_pkg::LEN_W'(1);
                        end
                    end
                end
                else
                begin
                    res_sym = empty ? END_SYM : pick_reg;
                    if (res_sym == END_SYM || len_inc >= cap || len_inc == '0)
                    begin
                        res_end       = 1'b1;
                        gen_prev_next = END_SYM;
                        gen_len_next  = '0;
                    end
                    else
                    begin
                        gen_prev_next = res_sym;
                        gen_len_next  = len_inc;
                    end
                end
            end
            lmg_pkg::MODE_RESTART:
            begin
                gen_prev_next = END_SYM;
                gen_len_next  = '0;
            end
            default:
            begin
                gen_prev_next = gen_prev_reg;
            end
        endcase
        sym_ext = {{lmg_pkg::SYMBOL_W{1'b0}}, res_sym};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lmg_pkg::MODE_TRAIN;
            letter_reg     <= '0;
            letter_ok_reg  <= 1'b0;
            train_prev_reg <= END_SYM;
            gen_prev_reg   <= END_SYM;
            gen_len_reg    <= '0;
            cap_reg        <= lmg_pkg::CAP_RESET;
            clr_addr_reg   <= '0;
            iss_col_reg    <= '0;
            iss_done_reg   <= 1'b0;
            rd_col_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            acc_reg        <= '0;
            pick_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (cmd.clear_step)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cmd.capture)
            begin
                mode_reg      <= s_tuser;
                letter_reg    <= letter_ext[SYM_W-1:0];
                letter_ok_reg <= letter_ext < (SYM_W + lmg_pkg::LETTER_W)'(ALPHABET_SIZE);
            end
            if (cmd.sweep_start)
            begin
                iss_col_reg  <= '0;
                iss_done_reg <= 1'b0;
                rd_vld_reg   <= 1'b0;
                acc_reg      <= '0;
            end
            else if (cmd.sweep_run)
            begin
                if (!iss_done_reg)
                begin
                    iss_done_reg <= iss_col_reg == last_col;
                    if (iss_col_reg != last_col)
                        iss_col_reg <= iss_col_reg + 1'b1;
                end
                rd_vld_reg <= !iss_done_reg;
                rd_col_reg <= iss_col_reg;
                if (rd_vld_reg)
                    acc_reg <= acc_sum;
                if (cmd.scan && hit)
                    pick_reg <= rd_col_reg;
            end
            if (cmd.finish)
            begin
                gen_prev_reg <= gen_prev_next;
                gen_len_reg  <= gen_len_next;
                if (mode_reg == lmg_pkg::MODE_END)
                    train_prev_reg <= END_SYM;
                else if (mode_reg == lmg_pkg::MODE_TRAIN && letter_ok_reg)
                    train_prev_reg <= letter_reg;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rnd_reg <= s_tdata[lmg_pkg::LETTER_W +: lmg_pkg::RAND_W];
        if (cmd.finish)
        begin
            sym_out_reg <= sym_ext[lmg_pkg::SYMBOL_W-1:0];
            wend_reg    <= res_end;
            stat_reg    <= res_stat;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.letter_ok  = letter_ok_reg;
        stat.train_open = train_prev_reg != END_SYM;
        stat.sweep_done = cmd.scan ? hit : (rd_vld_reg && rd_col_reg == last_col);
        stat.div_done   = div_done;
        stat.clear_done = clr_addr_reg == ADDR_W'(DEPTH - 1);
        stat.total_zero = empty;
        stat.out_free   = out_free;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, sym_out_reg};
    assign m_tlast  = wend_reg;
    assign m_tuser  = stat_reg;

endmodule

### rtl/core/lmg_ctrl.sv
// controller state machine sequencing clear, train, sum, divide and scan
module lmg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lmg_pkg::lmg_stat_t stat,
    output lmg_pkg::lmg_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DECODE   = 4'd2;
    localparam logic [3:0] ST_TRAIN    = 4'd3;
    localparam logic [3:0] ST_SUM      = 4'd4;
    localparam logic [3:0] ST_DIV_INIT = 4'd5;
    localparam logic [3:0] ST_DIV_RUN  = 4'd6;
    localparam logic [3:0] ST_SCAN     = 4'd7;
    localparam logic [3:0] ST_RESULT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                unique case (stat.mode)
                    lmg_pkg::MODE_TRAIN:
                        state_next = stat.letter_ok ? ST_TRAIN : ST_RESULT;
                    lmg_pkg::MODE_END:
                        state_next = stat.train_open ? ST_TRAIN : ST_RESULT;
                    lmg_pkg::MODE_DRAW:
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_SUM;
                    end
                    default:
                        state_next = ST_RESULT;
                endcase
            end
            ST_TRAIN:
            begin
                cmd.train_write = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_SUM:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                if (stat.total_zero)
                    state_next = ST_RESULT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN:
            begin
                if (stat.div_done)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.sweep_run = 1'b1;
                cmd.scan      = 1'b1;
                if (stat.sweep_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/letter_bigram_markov_generator_unit.sv
// top level of the letter bigram markov word generator
//
// channel  | signals                           | payload
// ---------+-----------------------------------+----------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser | tdata letter[4:0] random_value[36:5]
//          |                                   | tuser mode[1:0]
// output   | m_tvalid m_tready m_tdata m_tlast | tdata symbol[4:0], tlast word_end,
//          | m_tuser                           | tuser status
// config   | cfg_valid cfg_ready cfg_data      | max_word_length[5:0]
//
// one item at a time. train items read the count, write it back saturated, then give the result;
// restart and ignored items skip the write. a draw over an n-entry row (n = ALPHABET_SIZE + 1,
// n = ALPHABET_SIZE at word start) sums the row, runs the bit-serial remainder unit, then makes
// a cumulative pass that stops at the chosen entry; an empty table ends after the sum.
// the single count memory read port paces both passes.
// after reset a clearing pass over all (ALPHABET_SIZE+1)^2 entries zeroes the counts before
// the first transaction is taken; config writes are taken at any time.
// a result waiting on m_tready does not block the next input transaction.
module letter_bigram_markov_generator_unit #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // letter[4:0], random_value[36:5], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // symbol[4:0], zero pad
    output logic        m_tlast,
    output logic        m_tuser,   // status[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    lmg_pkg::lmg_cmd_t  cmd;
    lmg_pkg::lmg_stat_t stat;

    assign cfg_ready = 1'b1;

    lmg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lmg_dp #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### dv/letter_bigram_markov_generator_unit_checker.sv
// checker for the letter bigram generator: model, expected queue and compare
module letter_bigram_markov_generator_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          draws_seen,
    output int          words_ended
);

    localparam int NLET = 26;
    localparam int ROWL = NLET + 1;
    localparam logic [4:0] END_MARK = 5'd26;
    localparam logic [31:0] SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [4:0] symbol;
        logic       word_end;
        logic       status;
    } letter_result_t;

    logic [31:0]    first_letter_cnt [NLET];
    logic [31:0]    successor_cnt [NLET*ROWL];
    logic [4:0]     train_prev;
    logic [4:0]     gen_prev;
    logic [5:0]     gen_len;
    logic [5:0]     word_cap;
    letter_result_t expected_letters [$];

    function automatic logic [4:0] pick_entry(input int base, input int n,
                                              input logic [63:0] total, input logic [31:0] rnd,
                                              input bit from_start);
        logic [63:0] r;
        logic [63:0] acc;
        logic [31:0] c;
        r = ({32'd0, rnd} % total) + 64'd1;
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            c = from_start ? first_letter_cnt[i] : successor_cnt[base + i];
            acc += c;
            if (acc >= r && c != 0)
                return 5'(i);
        end
        return 5'(n - 1);
    endfunction

    function automatic letter_result_t predict_letter(input logic [1:0] mode,
                                                      input logic [4:0] letter,
                                                      input logic [31:0] rnd);
        letter_result_t res;
        logic [63:0] total;
        logic [5:0] cap;
        int base;
        res = '0;
        total = 0;
        cap = (word_cap == 0) ? 6'd1 : word_cap;
        case (mode)
            lmg_pkg::MODE_TRAIN:
            begin
                if (letter < NLET)
                begin
                    if (train_prev >= NLET)
                    begin
                        if (first_letter_cnt[letter] != SAT)
                            first_letter_cnt[letter]++;
                    end
                    else
                    begin
                        base = train_prev * ROWL + letter;
                        if (successor_cnt[base] != SAT)
                            successor_cnt[base]++;
                    end
                    train_prev = letter;
                end
            end
            lmg_pkg::MODE_END:
            begin
                if (train_prev < NLET)
                begin
                    base = train_prev * ROWL + NLET;
                    if (successor_cnt[base] != SAT)
                        successor_cnt[base]++;
                end
                train_prev = END_MARK;
            end
            lmg_pkg::MODE_DRAW:
            begin
                if (gen_prev >= NLET)
                begin
                    for (int i = 0; i < NLET; i++)
                        total += first_letter_cnt[i];
                    if (total == 0)
                    begin
                        res.symbol = END_MARK;
                        res.word_end = 1'b1;
                        res.status = 1'b1;
                    end
                    else
                    begin
                        res.symbol = pick_entry(0, NLET, total, rnd, 1'b1);
                        gen_prev = res.symbol;
                        gen_len = 6'd1;
                        if (gen_len >= cap)
                        begin
                            res.word_end = 1'b1;
                            gen_prev = END_MARK;
                            gen_len = 0;
                        end
                    end
                end
                else
                begin
                    base = gen_prev * ROWL;
                    for (int i = 0; i < ROWL; i++)
                        total += successor_cnt[base + i];
                    res.symbol = (total == 0) ? END_MARK
                               : pick_entry(base, ROWL, total, rnd, 1'b0);
                    if (res.symbol >= NLET)
                    begin
                        res.word_end = 1'b1;
                        gen_prev = END_MARK;
                        gen_len = 0;
                    end
                    else
                    begin
                        gen_prev = res.symbol;
                        gen_len = gen_len + 6'd1;
                        if (gen_len >= cap || gen_len == 0)
                        begin
                            res.word_end = 1'b1;
                            gen_prev = END_MARK;
                            gen_len = 0;
                        end
                    end
                end
            end
            default:
            begin
                gen_prev = END_MARK;
                gen_len = 0;
            end
        endcase
        return res;
    endfunction

    assign pending = expected_letters.size();

    always @(posedge clk or negedge rst_n)
    begin
        letter_result_t exp_res;
        letter_result_t got;
        if (!rst_n)
        begin
            foreach (first_letter_cnt[i]) first_letter_cnt[i] = 0;
            foreach (successor_cnt[i]) successor_cnt[i] = 0;
            train_prev = END_MARK;
            gen_prev = END_MARK;
            gen_len = 0;
            word_cap = lmg_pkg::CAP_RESET;
            expected_letters.delete();
            fail_count <= 0;
            draws_seen <= 0;
            words_ended <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                word_cap = cfg_data;
            if (s_tvalid && s_tready)
            begin
                expected_letters.push_back(predict_letter(s_tuser, s_tdata[4:0],
                                                          s_tdata[36:5]));
                if (s_tuser == lmg_pkg::MODE_DRAW)
                    draws_seen <= draws_seen + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got.symbol = m_tdata[4:0];
                got.word_end = m_tlast;
                got.status = m_tuser;
                if (got.word_end)
                    words_ended <= words_ended + 1;
                if (expected_letters.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected transaction: symbol %0d end %0b status %0b",
                                 got.symbol, got.word_end, got.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = expected_letters.pop_front();
                    if (got != exp_res || m_tdata[7:5] != 0)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: expected sym %0d end %0b st %0b,",
                                      " got sym %0d end %0b st %0b"},
                                     exp_res.symbol, exp_res.word_end, exp_res.status,
                                     got.symbol, got.word_end, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/letter_bigram_markov_generator_unit_tb.sv
// testbench top: stimulus, idling and verdict for the letter bigram generator
module letter_bigram_markov_generator_unit_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          draws_seen;
    int          words_ended;
    int          cycle_count;
    int          gap_left;
    int          stall_mode;

    letter_bigram_markov_generator_unit uut (.*);

    letter_bigram_markov_generator_unit_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // receiver stalls: phases of always-ready, random and heavy back-pressure
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("timeout waiting for transactions");
            $display("status: fail");
            $finish;
        end
    end

    // tvalid stays high after an accepted transaction unless a gap or a drain follows
    task automatic send_item(input logic [1:0] mode, input logic [4:0] letter,
                             input logic [31:0] rnd);
        if (gap_left == 0 && $urandom_range(0, 9) == 0)
            gap_left = $urandom_range(1, 60);
        if (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            while (gap_left > 0)
            begin
                @(posedge clk);
                gap_left--;
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, rnd, letter};
        s_tuser <= mode;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_cap(input logic [5:0] cap);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic train_word(input int len, input int vocab);
        for (int i = 0; i < len; i++)
            send_item(lmg_pkg::MODE_TRAIN, 5'($urandom_range(0, vocab - 1)), $urandom);
        send_item(lmg_pkg::MODE_END, 5'($urandom), $urandom);
    endtask

    initial
    begin
        int sent;
        int kind;
        int len;
        logic [5:0] caps [4];
        caps = '{6'd0, 6'd1, 6'd63, 6'd5};
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = lmg_pkg::MODE_TRAIN;
        m_tready = 0;
        cfg_valid = 0;
        cfg_data = 0;
        cycle_count = 0;
        gap_left = 0;
        stall_mode = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty start table, ignored letters, end with no open word, restart
        send_item(lmg_pkg::MODE_DRAW, 5'd0, 32'hFFFF_FFFF);
        send_item(lmg_pkg::MODE_END, 5'd0, 32'd0);
        send_item(lmg_pkg::MODE_TRAIN, 5'd31, 32'd0);
        send_item(lmg_pkg::MODE_TRAIN, 5'd26, 32'hFFFF_FFFF);
        send_item(lmg_pkg::MODE_DRAW, 5'd0, 32'd0);
        send_item(lmg_pkg::MODE_TRAIN, 5'd0, 32'd0);
        send_item(lmg_pkg::MODE_TRAIN, 5'd25, 32'd0);
        send_item(lmg_pkg::MODE_TRAIN, 5'd31, 32'd0);
        send_item(lmg_pkg::MODE_END, 5'd0, 32'd0);
        send_item(lmg_pkg::MODE_TRAIN, 5'd25, 32'd0);
        send_item(lmg_pkg::MODE_TRAIN, 5'd25, 32'd0);
        send_item(lmg_pkg::MODE_DRAW, 5'd0, 32'd0);
        send_item(lmg_pkg::MODE_DRAW, 5'd0, 32'hFFFF_FFFF);
        send_item(lmg_pkg::MODE_DRAW, 5'd0, 32'h8000_0000);
        send_item(lmg_pkg::MODE_RESTART, 5'd0, 32'd0);
        send_item(lmg_pkg::MODE_DRAW, 5'd0, 32'hFFFF_FFFF);
        send_item(lmg_pkg::MODE_DRAW, 5'd0, 32'h5555_5555);
        send_item(lmg_pkg::MODE_END, 5'd0, 32'd0);
        drain_results();

        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_cap(caps[phase]);
            while (sent < (phase + 1) * 460)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 3)
                begin
                    len = $urandom_range(1, 8);
                    train_word(len, $urandom_range(3, 26));
                    sent += len + 1;
                end
                else if (kind < 8)
                begin
                    send_item(lmg_pkg::MODE_DRAW, 5'($urandom), $urandom);
                    sent++;
                end
                else if (kind == 8)
                begin
                    send_item(lmg_pkg::MODE_RESTART, 5'($urandom), $urandom);
                    sent++;
                end
                else
                begin
                    send_item(2'($urandom_range(0, 1)), 5'($urandom), $urandom);
                    sent++;
                end
            end
            drain_results();
        end
        write_cap(6'd63);
        drain_results();

        $display("covered %0d draws, %0d word ends, caps 0, 1, 63, 5 and 63",
                 draws_seen, words_ended);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
